// ===== rtl/krht_pkg.sv =====
package krht_pkg;

    localparam int NUM_SLOTS_DEF     = 8;
    localparam int HISTORY_DEPTH_DEF = 64;

    localparam int ID_W    = 32;
    localparam int KIND_W  = 8;
    localparam int TIME_W  = 32;
    localparam int VALUE_W = 32;
    localparam int SLOT_W  = 3;
    localparam int FILL_W  = 7;

    typedef logic [ID_W-1:0]           sensor_id_t;
    typedef logic [KIND_W-1:0]         reading_kind_t;
    typedef logic [TIME_W-1:0]         time_ms_t;
    typedef logic signed [VALUE_W-1:0] reading_value_t;
    typedef logic [SLOT_W-1:0]         slot_index_t;
    typedef logic [FILL_W-1:0]         fill_count_t;

endpackage

// ===== rtl/krht_event_if.sv =====
interface krht_event_if;
    import krht_pkg::*;

    logic           valid;
    logic           ready;
    sensor_id_t     sensor_id;
    reading_kind_t  reading_kind;
    time_ms_t       time_ms;
    reading_value_t reading_value;

    modport source (
        output valid, sensor_id, reading_kind, time_ms, reading_value,
        input  ready
    );

    modport sink (
        input  valid, sensor_id, reading_kind, time_ms, reading_value,
        output ready
    );
endinterface

// ===== rtl/krht_result_if.sv =====
interface krht_result_if;
    import krht_pkg::*;

    logic        valid;
    logic        ready;
    slot_index_t slot_index;
    logic        dropped;
    fill_count_t fill_count;

    modport source (
        output valid, slot_index, dropped, fill_count,
        input  ready
    );

    modport sink (
        input  valid, slot_index, dropped, fill_count,
        output ready
    );
endinterface

// ===== rtl/keyed_ring_history_table_core.sv =====
// keyed ring history table
// events: one sensor sample per transaction (id, kind, timestamp, q31 value)
// results: one transaction per event giving the slot used, a drop flag and
//   the slot's fill count after the push
// an event is matched against the stored (id, kind) keys of all valid slots;
// on a miss it claims the lowest free slot, and with no free slot it is
// dropped with slot_index and fill_count of zero
// an accepted event passes the input register, then the result register; one
//   event per cycle is sustained while the result receiver is ready, with the
//   key compare and slot update done combinationally between the two registers
// the next event sees the slot state left by the previous one, so events
//   back to back on the same key are handled in order
// reset clears all slot valid bits at once; sample history is not cleared
// when the result receiver stalls, the result register holds and the input
//   register still takes one more event, after which events are held off
module keyed_ring_history_table_core #(
    parameter int NUM_SLOTS     = krht_pkg::NUM_SLOTS_DEF,
    parameter int HISTORY_DEPTH = krht_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    krht_event_if.sink           events,
    krht_result_if.source        results
);
    import krht_pkg::*;

    localparam int SI_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int HD_W = $clog2(HISTORY_DEPTH);
    localparam int FC_W = $clog2(HISTORY_DEPTH + 1);

    // input register
    logic           in_vld_reg;
    sensor_id_t     id_reg;
    reading_kind_t  kind_reg;
    time_ms_t       time_reg;
    reading_value_t value_reg;

    // slot state
    logic [NUM_SLOTS-1:0] slot_valid_reg;
    sensor_id_t           slot_id_reg   [NUM_SLOTS];
    reading_kind_t        slot_kind_reg [NUM_SLOTS];
    logic [HD_W-1:0]      slot_head_reg [NUM_SLOTS];
    logic [FC_W-1:0]      slot_fill_reg [NUM_SLOTS];

    // sample history
    time_ms_t       time_mem  [NUM_SLOTS][HISTORY_DEPTH];
    reading_value_t value_mem [NUM_SLOTS][HISTORY_DEPTH];

    // result register
    logic        out_vld_reg;
    slot_index_t slot_out_reg;
    logic        drop_out_reg;
    fill_count_t fill_out_reg;

    logic            advance;
    logic            hit_found;
    logic [SI_W-1:0] hit_idx;
    logic            free_found;
    logic [SI_W-1:0] free_idx;
    logic            take;
    logic [SI_W-1:0] sel_idx;
    logic [HD_W-1:0] cur_head;
    logic [FC_W-1:0] cur_fill;
    logic [HD_W-1:0] head_next;
    logic [FC_W-1:0] fill_next;
    logic [SI_W+SLOT_W-1:0] slot_wide;
    logic [FC_W+FILL_W-1:0] fill_wide;

    assign advance      = in_vld_reg && (!out_vld_reg || results.ready);
    assign events.ready = !in_vld_reg || !out_vld_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (events.ready)
        begin
            in_vld_reg <= events.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (events.valid && events.ready)
        begin
            id_reg    <= events.sensor_id;
            kind_reg  <= events.reading_kind;
            time_reg  <= events.time_ms;
            value_reg <= events.reading_value;
        end
    end

    // lowest-numbered matching slot and lowest-numbered free slot
    always_comb
    begin
        hit_found  = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (slot_valid_reg[i] && slot_id_reg[i] == id_reg
                && slot_kind_reg[i] == kind_reg)
            begin
                hit_found = 1'b1;
                hit_idx   = SI_W'(i);
            end
            if (!slot_valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SI_W'(i);
            end
        end
    end

    always_comb
    begin
        take    = hit_found || free_found;
        sel_idx = hit_found ? hit_idx : free_idx;
        // a freshly claimed slot starts from an empty ring
        cur_head = hit_found ? slot_head_reg[hit_idx] : '0;
        cur_fill = hit_found ? slot_fill_reg[hit_idx] : '0;
        if (cur_head == HD_W'(HISTORY_DEPTH - 1))
        begin
            head_next = '0;
        end
        else
        begin
            head_next = cur_head + HD_W'(1);
        end
        if (cur_fill == FC_W'(HISTORY_DEPTH))
        begin
            fill_next = cur_fill;
        end
        else
        begin
            fill_next = cur_fill + FC_W'(1);
        end
        slot_wide = {{SLOT_W{1'b0}}, sel_idx};
        fill_wide = {{FILL_W{1'b0}}, fill_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
        end
        else if (advance && !hit_found && free_found)
        begin
            slot_valid_reg[free_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && take)
        begin
            slot_id_reg[sel_idx]   <= id_reg;
            slot_kind_reg[sel_idx] <= kind_reg;
            slot_head_reg[sel_idx] <= head_next;
            slot_fill_reg[sel_idx] <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && take)
        begin
            time_mem[sel_idx][cur_head]  <= time_reg;
            value_mem[sel_idx][cur_head] <= value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            slot_out_reg <= take ? slot_wide[SLOT_W-1:0] : '0;
            drop_out_reg <= !take;
            fill_out_reg <= take ? fill_wide[FILL_W-1:0] : '0;
        end
    end

    assign results.valid      = out_vld_reg;
    assign results.slot_index = slot_out_reg;
    assign results.dropped    = drop_out_reg;
    assign results.fill_count = fill_out_reg;

endmodule

// ===== tb/sv/tb_keyed_ring_history_table_core.sv =====
module tb_keyed_ring_history_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    import krht_pkg::*;

    localparam int SLOTS        = NUM_SLOTS_DEF;
    localparam int DEPTH        = HISTORY_DEPTH_DEF;
    localparam int LONG_HOLD    = 48;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        slot_index_t slot_index;
        logic        dropped;
        fill_count_t fill_count;
    } slot_result_t;

    logic clk;
    logic rst_n;

    krht_event_if  event_ch ();
    krht_result_if result_ch ();

    keyed_ring_history_table_core #(
        .NUM_SLOTS     (SLOTS),
        .HISTORY_DEPTH (DEPTH)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .events  (event_ch.sink),
        .results (result_ch.source)
    );

    // own copy of the slot table, updated on every accepted transaction
    bit            slot_taken [SLOTS];
    sensor_id_t    slot_owner_id [SLOTS];
    reading_kind_t slot_owner_kind [SLOTS];
    int unsigned   slot_samples [SLOTS];

    slot_result_t expected_results [$];

    int  send_idle_pct;
    int  recv_idle_pct;
    int  fail_count;
    bit  hold_req;
    int  hold_left;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic slot_result_t predict_slot_push(input sensor_id_t id,
                                                       input reading_kind_t kind);
        slot_result_t r;
        int           hit;
        hit = -1;
        for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && slot_taken[i] && slot_owner_id[i] == id
                && slot_owner_kind[i] == kind)
                hit = i;
        // miss: claim the lowest free slot and start its history empty
        if (hit < 0)
            for (int i = 0; i < SLOTS; i++)
                if (hit < 0 && !slot_taken[i])
                begin
                    hit                = i;
                    slot_taken[i]      = 1'b1;
                    slot_owner_id[i]   = id;
                    slot_owner_kind[i] = kind;
                    slot_samples[i]    = 0;
                end
        if (hit < 0)
        begin
            r.slot_index = '0;
            r.dropped    = 1'b1;
            r.fill_count = '0;
        end
        else
        begin
            if (slot_samples[hit] < DEPTH)
                slot_samples[hit]++;
            r.slot_index = slot_index_t'(hit);
            r.dropped    = 1'b0;
            r.fill_count = fill_count_t'(slot_samples[hit]);
        end
        return r;
    endfunction

    // entered and left at a falling edge; valid stays high between back-to-back events
    task automatic send_event(input sensor_id_t id, input reading_kind_t kind,
                              input time_ms_t stamp, input reading_value_t value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            event_ch.valid <= 1'b0;
            @(negedge clk);
        end
        event_ch.valid         <= 1'b1;
        event_ch.sensor_id     <= id;
        event_ch.reading_kind  <= kind;
        event_ch.time_ms       <= stamp;
        event_ch.reading_value <= value;
        do
            @(posedge clk);
        while (event_ch.ready !== 1'b1);
        expected_results.push_back(predict_slot_push(id, kind));
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin : result_receiver
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : result_check
        slot_result_t want;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transaction with nothing expected: slot_index %0d dropped %0b",
                       result_ch.slot_index, result_ch.dropped);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result_ch.slot_index !== want.slot_index)
                begin
                    $error("slot_index expected %0d actual %0d",
                           want.slot_index, result_ch.slot_index);
                    fail_count++;
                end
                if (result_ch.dropped !== want.dropped)
                begin
                    $error("dropped expected %0b actual %0b", want.dropped, result_ch.dropped);
                    fail_count++;
                end
                if (result_ch.fill_count !== want.fill_count)
                begin
                    $error("fill_count expected %0d actual %0d",
                           want.fill_count, result_ch.fill_count);
                    fail_count++;
                end
            end
        end
    end

    // fills all slots with extreme keys, checks the key match needs both id and kind,
    // then drops events once no slot is free
    task automatic test_slot_claim_and_drop();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_event(32'h0000_0000, 8'h00, 32'h0000_0000, 32'sh8000_0000);
        send_event(32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
        send_event(32'h0000_0000, 8'hFF, 32'h0000_0001, 32'sh0000_0000);
        send_event(32'hFFFF_FFFF, 8'h00, 32'h8000_0000, -32'sd1);
        send_event(32'h0000_0000, 8'h00, 32'h7FFF_FFFF, 32'sh0000_0001);
        send_event(32'hA5A5_5A5A, 8'h3C, $urandom, reading_value_t'($urandom));
        send_event(32'h5A5A_A5A5, 8'hC3, $urandom, reading_value_t'($urandom));
        send_event(32'h0000_0001, 8'h01, $urandom, reading_value_t'($urandom));
        send_event(32'h8000_0000, 8'h80, $urandom, reading_value_t'($urandom));
        // table is full from here on
        send_event(32'hFFFF_FFFF, 8'h01, 32'hFFFF_FFFF, 32'sh8000_0000);
        send_event(32'h0000_0000, 8'h80, 32'h0000_0000, 32'sh7FFF_FFFF);
        send_event($urandom, reading_kind_t'($urandom), $urandom, reading_value_t'($urandom));
        send_event(32'h8000_0000, 8'h80, $urandom, reading_value_t'($urandom));
        send_event(32'hFFFF_FFFF, 8'hFF, 32'h0000_0000, -32'sd1);
        send_event(32'hFFFF_FFFF, 8'h00, 32'hFFFF_FFFF, 32'sh0000_0000);
        send_event(32'h0000_0000, 8'hFF, $urandom, reading_value_t'($urandom));
    endtask

    // hammers two keys well past the history depth so the count saturates
    task automatic test_history_wrap();
        int pick;
        send_idle_pct = 10;
        recv_idle_pct = 10;
        repeat (150)
        begin
            pick = $urandom_range(1) ? 0 : 3;
            send_event(slot_owner_id[pick], slot_owner_kind[pick], $urandom,
                       reading_value_t'($urandom));
        end
    endtask

    // mostly hits on stored keys, with near misses and fresh keys that get dropped
    task automatic test_random_mix(input int count, input int send_pct, input int recv_pct);
        int            roll;
        int            pick;
        sensor_id_t    id;
        reading_kind_t kind;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count)
        begin
            roll = $urandom_range(99);
            pick = $urandom_range(SLOTS - 1);
            id   = slot_owner_id[pick];
            kind = slot_owner_kind[pick];
            if (roll >= 94)
            begin
                id   = $urandom;
                kind = reading_kind_t'($urandom);
            end
            else if (roll >= 90)
                kind = kind ^ reading_kind_t'(1 << $urandom_range(KIND_W - 1));
            else if (roll >= 86)
                id = id ^ (sensor_id_t'(1) << $urandom_range(ID_W - 1));
            send_event(id, kind, $urandom, reading_value_t'($urandom));
        end
    endtask

    // receiver stalls for a long stretch while events keep coming
    task automatic test_backpressure();
        int pick;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        event_ch.valid <= 1'b0;
        @(negedge clk);
        repeat (84)
        begin
            pick = $urandom_range(SLOTS - 1);
            send_event(slot_owner_id[pick], slot_owner_kind[pick], $urandom,
                       reading_value_t'($urandom));
        end
    endtask

    initial
    begin : main_sequence
        clk                    = 1'b0;
        rst_n                  = 1'b0;
        event_ch.valid         = 1'b0;
        event_ch.sensor_id     = '0;
        event_ch.reading_kind  = '0;
        event_ch.time_ms       = '0;
        event_ch.reading_value = '0;
        result_ch.ready        = 1'b0;
        send_idle_pct          = 0;
        recv_idle_pct          = 0;
        fail_count             = 0;
        hold_req               = 1'b0;
        hold_left              = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_slot_claim_and_drop();
        test_history_wrap();
        test_random_mix(500, 26, 62);
        test_random_mix(500, 62, 26);
        test_random_mix(500, 0, 0);
        test_backpressure();

        event_ch.valid <= 1'b0;
        recv_idle_pct = 0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
